/* rtl/bilinear_grid_interpolator_unit_defines.svh */
// Assertion macros shared by the checker of the bilinear grid interpolator.
// Stand-alone header; it is pulled in by the files that assert.
`ifndef BILINEAR_GRID_INTERPOLATOR_UNIT_DEFINES_SVH
`define BILINEAR_GRID_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define BGI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bgi: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define BGI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bgi: next-cycle check failed");

// Next-cycle implication that also holds during reset.
`define BGI_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bgi: reset check failed");

`endif

/* rtl/bgi_pkg.sv */
// Package of the bilinear grid interpolator: defaults, register map and
// the fixed-point helper functions. It depends on nothing else.
`default_nettype none
package bgi_pkg;

    localparam int DEF_GRID_X     = 64;
    localparam int DEF_GRID_Y     = 64;
    localparam int DEF_COMPONENTS = 5;
    localparam int MAX_COMPONENTS = 5;
    localparam int CFG_ADDR_W     = 5;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_X_ORIGIN   = 3'd0,
        REG_Y_ORIGIN   = 3'd1,
        REG_X_INV_STEP = 3'd2,
        REG_Y_INV_STEP = 3'd3,
        REG_X_COUNT    = 3'd4,
        REG_Y_COUNT    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic        oor;
        logic [31:0] idx;
        logic [16:0] w;
    } loc_t;

    // Cell index and Q1.16 weight along one axis from the Q32.32 product.
    function automatic loc_t locate(input logic [63:0] prod, input logic neg,
                                    input logic [31:0] n);
        loc_t r;
        r.oor  = 1'b1;
        r.idx  = '0;
        r.w    = '0;
        if (!neg && n >= 32'd2) begin
            if (prod[63:32] < n - 32'd1) begin
                r.oor  = 1'b0;
                r.idx  = prod[63:32];
                r.w    = {1'b0, prod[31:16]};
            end else if (prod[63:32] == n - 32'd1 && prod[31:16] == 16'd0) begin
                // A point on the last grid line uses the last cell at full weight.
                r.oor  = 1'b0;
                r.idx  = n - 32'd2;
                r.w    = ONE_Q16[16:0];
            end
        end
        return r;
    endfunction

    // a*(1-w) + b*w, written as a*2^16 + (b-a)*w, exact.
    function automatic logic signed [51:0] blend_sum(input logic signed [31:0] a,
                                                     input logic signed [31:0] b,
                                                     input logic [16:0] w);
        logic signed [32:0] diff;
        logic signed [50:0] prod;
        diff = {b[31], b} - {a[31], a};
        prod = diff * $signed({1'b0, w});
        return {{4{a[31]}}, a, 16'd0} + {prod[50], prod};
    endfunction

    // Round half up to Q16.16; the blend is convex, so 32 bits suffice.
    function automatic logic signed [31:0] round_q16(input logic signed [51:0] s);
        logic signed [51:0] r;
        r = s + 52'sd32768;
        return r[47:16];
    endfunction

    function automatic logic signed [31:0] round_sat_q16(input logic signed [51:0] s);
        logic signed [51:0] r;
        r = s + 52'sd32768;
        if (r[51:47] == 5'b00000 || r[51:47] == 5'b11111) begin
            return r[47:16];
        end else if (r[51]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/bilinear_grid_interpolator_unit.sv */
// Bilinear interpolator over a uniform grid of up to five Q16.16 components.
// Depends on bgi_pkg and bgi_ram.
`default_nettype none
// The block takes one word per cycle and has eight pipeline stages from an
// accepted word to its result: origin subtract, the 32x32 coordinate multiply,
// cell location, the grid read, x blend multiply, x rounding, y blend multiply
// and final rounding. The grid is split over four banks by the parity of row
// and column, so the four corners of a cell are read in one cycle. Loads and
// queries keep their order; a load is written when it reaches the read stage,
// and a query that follows it sees the new samples. Loads give no result.
// The whole pipeline holds while a result waits on m_ready.
module bilinear_grid_interpolator_unit import bgi_pkg::*; #(
    parameter int GRID_X     = DEF_GRID_X,
    parameter int GRID_Y     = DEF_GRID_Y,
    parameter int COMPONENTS = DEF_COMPONENTS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_mode,
    input  wire logic [5:0]            s_grid_col,
    input  wire logic [5:0]            s_grid_row,
    input  wire logic signed [31:0]    s_sample_0,
    input  wire logic signed [31:0]    s_sample_1,
    input  wire logic signed [31:0]    s_sample_2,
    input  wire logic signed [31:0]    s_sample_3,
    input  wire logic signed [31:0]    s_sample_4,
    input  wire logic signed [31:0]    s_point_x,
    input  wire logic signed [31:0]    s_point_y,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [31:0]         m_value_0,
    output logic signed [31:0]         m_value_1,
    output logic signed [31:0]         m_value_2,
    output logic signed [31:0]         m_value_3,
    output logic signed [31:0]         m_value_4,
    output logic                       m_out_of_range,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    localparam int CXW   = $clog2(GRID_X);
    localparam int CYW   = $clog2(GRID_Y);
    localparam int HX    = (GRID_X + 1) / 2;
    localparam int HY    = (GRID_Y + 1) / 2;
    localparam int BDEPTH = HX * HY;
    localparam int AW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int DW    = COMPONENTS * 32;

    // Configuration registers
    logic signed [31:0] x_origin_reg, y_origin_reg;
    logic [31:0]        x_inv_step_reg, y_inv_step_reg;
    logic [6:0]         x_count_reg, y_count_reg;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg   <= '0;
            y_origin_reg   <= '0;
            x_inv_step_reg <= ONE_Q16;
            y_inv_step_reg <= ONE_Q16;
            x_count_reg    <= 7'd64;
            y_count_reg    <= 7'd64;
        end else if (cfg_we) begin
            case (cfg_reg_t'(paddr[4:2]))
                REG_X_ORIGIN:   x_origin_reg   <= pwdata;
                REG_Y_ORIGIN:   y_origin_reg   <= pwdata;
                REG_X_INV_STEP: x_inv_step_reg <= pwdata;
                REG_Y_INV_STEP: y_inv_step_reg <= pwdata;
                REG_X_COUNT:    x_count_reg    <= pwdata[6:0];
                REG_Y_COUNT:    y_count_reg    <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg_t'(paddr[4:2]))
            REG_X_ORIGIN:   prdata = x_origin_reg;
            REG_Y_ORIGIN:   prdata = y_origin_reg;
            REG_X_INV_STEP: prdata = x_inv_step_reg;
            REG_Y_INV_STEP: prdata = y_inv_step_reg;
            REG_X_COUNT:    prdata = {25'd0, x_count_reg};
            REG_Y_COUNT:    prdata = {25'd0, y_count_reg};
            default:        prdata = '0;
        endcase
    end

    // Whole-pipeline advance
    logic m_valid_reg;
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    logic [DW-1:0] smp_in;
    always_comb begin
        logic [MAX_COMPONENTS*32-1:0] all;
        all = {s_sample_4, s_sample_3, s_sample_2, s_sample_1, s_sample_0};
        smp_in = all[DW-1:0];
    end

    // Stage 1: offsets from the origin
    logic               v1_reg, mode1_reg;
    logic [5:0]         col1_reg, row1_reg;
    logic [DW-1:0]      smp1_reg;
    logic signed [32:0] dx1_reg, dy1_reg;

    // Stage 2: Q32.32 products
    logic               v2_reg, mode2_reg, negx2_reg, negy2_reg;
    logic [5:0]         col2_reg, row2_reg;
    logic [DW-1:0]      smp2_reg;
    logic [63:0]        px2_reg, py2_reg;

    // Stage 3: located cell
    logic               v3_reg, mode3_reg, oor3_reg;
    logic [5:0]         col3_reg, row3_reg;
    logic [DW-1:0]      smp3_reg;
    logic [CXW-1:0]     cx3_reg;
    logic [CYW-1:0]     cy3_reg;
    logic [16:0]        wx3_reg, wy3_reg;

    // Stage 4: grid data
    logic               v4_reg, mode4_reg, oor4_reg, parx4_reg, pary4_reg;
    logic [16:0]        wx4_reg, wy4_reg;
    logic [DW-1:0]      rd_data [4];

    // Stages 5 to 8
    logic               v5_reg, mode5_reg, oor5_reg;
    logic [16:0]        wy5_reg;
    logic signed [51:0] lsum5_reg [COMPONENTS];
    logic signed [51:0] hsum5_reg [COMPONENTS];
    logic               v6_reg, mode6_reg, oor6_reg;
    logic [16:0]        wy6_reg;
    logic signed [31:0] lo6_reg [COMPONENTS];
    logic signed [31:0] hi6_reg [COMPONENTS];
    logic               v7_reg, mode7_reg, oor7_reg;
    logic signed [51:0] ysum7_reg [COMPONENTS];
    logic               oor8_reg;
    logic signed [31:0] val8_reg [COMPONENTS];

    logic [31:0] nx, ny;
    loc_t        locx_next, locy_next;
    logic        load_ok;

    assign nx = (32'(x_count_reg) < 32'(GRID_X)) ? 32'(x_count_reg) : 32'(GRID_X);
    assign ny = (32'(y_count_reg) < 32'(GRID_Y)) ? 32'(y_count_reg) : 32'(GRID_Y);
    assign locx_next = locate(px2_reg, negx2_reg, nx);
    assign locy_next = locate(py2_reg, negy2_reg, ny);
    assign load_ok = (32'(col3_reg) < 32'(GRID_X)) && (32'(row3_reg) < 32'(GRID_Y));

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            m_valid_reg <= v7_reg && mode7_reg;
        end
    end

    // Address path payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            mode1_reg <= s_mode;
            col1_reg  <= s_grid_col;
            row1_reg  <= s_grid_row;
            smp1_reg  <= smp_in;
            dx1_reg   <= {s_point_x[31], s_point_x} - {x_origin_reg[31], x_origin_reg};
            dy1_reg   <= {s_point_y[31], s_point_y} - {y_origin_reg[31], y_origin_reg};

            mode2_reg <= mode1_reg;
            col2_reg  <= col1_reg;
            row2_reg  <= row1_reg;
            smp2_reg  <= smp1_reg;
            negx2_reg <= dx1_reg[32];
            negy2_reg <= dy1_reg[32];
            px2_reg   <= {32'd0, dx1_reg[31:0]} * {32'd0, x_inv_step_reg};
            py2_reg   <= {32'd0, dy1_reg[31:0]} * {32'd0, y_inv_step_reg};

            mode3_reg <= mode2_reg;
            col3_reg  <= col2_reg;
            row3_reg  <= row2_reg;
            smp3_reg  <= smp2_reg;
            oor3_reg  <= locx_next.oor || locy_next.oor;
            cx3_reg   <= locx_next.idx[CXW-1:0];
            cy3_reg   <= locy_next.idx[CYW-1:0];
            wx3_reg   <= locx_next.w;
            wy3_reg   <= locy_next.w;

            mode4_reg <= mode3_reg;
            oor4_reg  <= oor3_reg;
            parx4_reg <= cx3_reg[0];
            pary4_reg <= cy3_reg[0];
            wx4_reg   <= wx3_reg;
            wy4_reg   <= wy3_reg;
        end
    end

    function automatic logic [AW-1:0] bank_addr(input int r, input int c);
        return AW'((r >> 1) * HX + (c >> 1));
    endfunction

    // Four banks, one for each parity of row and column
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PR = 1'(b / 2);
        localparam logic PC = 1'(b % 2);
        int          rsel, csel;
        logic        we;
        logic [AW-1:0] raddr;

        always_comb begin
            rsel  = (cy3_reg[0] == PR) ? int'(cy3_reg) : int'(cy3_reg) + 1;
            csel  = (cx3_reg[0] == PC) ? int'(cx3_reg) : int'(cx3_reg) + 1;
            raddr = bank_addr(rsel, csel);
            we    = adv && v3_reg && !mode3_reg && load_ok &&
                    row3_reg[0] == PR && col3_reg[0] == PC;
        end

        bgi_ram #(.WIDTH(DW), .DEPTH(BDEPTH)) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (bank_addr(int'(row3_reg), int'(col3_reg))),
            .wdata (smp3_reg),
            .re    (adv),
            .raddr (raddr),
            .rdata (rd_data[b])
        );
    end

    logic [1:0] b11, b21, b12, b22;
    assign b11 = {pary4_reg, parx4_reg};
    assign b21 = {pary4_reg, !parx4_reg};
    assign b12 = {!pary4_reg, parx4_reg};
    assign b22 = {!pary4_reg, !parx4_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode5_reg <= mode4_reg; oor5_reg <= oor4_reg; wy5_reg <= wy4_reg;
            mode6_reg <= mode5_reg; oor6_reg <= oor5_reg; wy6_reg <= wy5_reg;
            mode7_reg <= mode6_reg; oor7_reg <= oor6_reg;
            oor8_reg  <= oor7_reg;
        end
    end

    // Per-component blend lanes
    for (genvar k = 0; k < COMPONENTS; k++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (adv) begin
                lsum5_reg[k] <= blend_sum(rd_data[b11][32*k +: 32],
                                          rd_data[b21][32*k +: 32], wx4_reg);
                hsum5_reg[k] <= blend_sum(rd_data[b12][32*k +: 32],
                                          rd_data[b22][32*k +: 32], wx4_reg);
                lo6_reg[k]   <= round_q16(lsum5_reg[k]);
                hi6_reg[k]   <= round_q16(hsum5_reg[k]);
                ysum7_reg[k] <= blend_sum(lo6_reg[k], hi6_reg[k], wy6_reg);
                val8_reg[k]  <= oor7_reg ? 32'sd0 : round_sat_q16(ysum7_reg[k]);
            end
        end
    end

    logic signed [31:0] out_val [MAX_COMPONENTS];
    for (genvar k = 0; k < MAX_COMPONENTS; k++) begin : g_out
        if (k < COMPONENTS) begin : g_used
            assign out_val[k] = val8_reg[k];
        end else begin : g_zero
            assign out_val[k] = 32'sd0;
        end
    end

    assign m_value_0      = out_val[0];
    assign m_value_1      = out_val[1];
    assign m_value_2      = out_val[2];
    assign m_value_3      = out_val[3];
    assign m_value_4      = out_val[4];
    assign m_out_of_range = oor8_reg;
endmodule
`default_nettype wire

/* rtl/bgi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/bgi_checker.sv */
// Port-level checks of the bilinear grid interpolator, bound to its top level.
// Depends on bilinear_grid_interpolator_unit_defines.svh.
`default_nettype none
`include "bilinear_grid_interpolator_unit_defines.svh"
module bgi_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_value_0,
    input wire logic signed [31:0] m_value_1,
    input wire logic signed [31:0] m_value_2,
    input wire logic signed [31:0] m_value_3,
    input wire logic signed [31:0] m_value_4,
    input wire logic               m_out_of_range,
    input wire logic               psel,
    input wire logic               pready
);
    // A word held back by the sink stays valid and keeps its first value and its range flag.
    `BGI_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_value_0) && $stable(m_out_of_range))
    // An out-of-range result carries zero values.
    `BGI_ASSERT_IMP(a_oor_zero, aclk, aresetn, m_valid && m_out_of_range,
        m_value_0 == 32'sd0 && m_value_1 == 32'sd0 && m_value_2 == 32'sd0 &&
        m_value_3 == 32'sd0 && m_value_4 == 32'sd0)
    // The input never stalls while the sink is taking results.
    `BGI_ASSERT_IMP(a_ready_follows, aclk, aresetn, m_ready || !m_valid, s_ready)
    // Reset empties the result register.
    `BGI_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)
    // The register port never inserts wait states.
    `BGI_ASSERT_IMP(a_pready, aclk, aresetn, psel, pready)
endmodule

bind bilinear_grid_interpolator_unit bgi_checker u_bgi_checker (.*);
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench of bilinear_grid_interpolator_unit: grid loads, queries and APB setup.
// It predicts each result from its own model of the grid and the registers, or takes it from the directed word.
// It depends on bgi_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module testbench;
    import bgi_pkg::*;

    localparam int WATCH_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 12;
    localparam int RAND_ITEMS  = 95;

    typedef struct packed {
        logic             mode;
        logic [5:0]       col;
        logic [5:0]       row;
        logic [4:0][31:0] smp;
        logic [31:0]      px;
        logic [31:0]      py;
        logic             typed;
        logic [4:0][31:0] val;
        logic             oor;
    } word_t;

    typedef struct packed {
        logic [4:0][31:0] val;
        logic             oor;
    } interp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_mode = 1'b0, m_ready = 1'b0;
    logic [5:0] s_grid_col = '0, s_grid_row = '0;
    logic signed [31:0] s_sample_0 = '0, s_sample_1 = '0, s_sample_2 = '0;
    logic signed [31:0] s_sample_3 = '0, s_sample_4 = '0, s_point_x = '0, s_point_y = '0;
    logic s_ready, m_valid, m_out_of_range, pready;
    logic signed [31:0] m_value_0, m_value_1, m_value_2, m_value_3, m_value_4;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;

    // Model state: the grid, which entries hold data, and the register copy.
    logic signed [31:0] grid_store [5][64][64];
    bit                 loaded [64][64];
    logic signed [31:0] x_org, y_org;
    logic [31:0]        x_inv, y_inv;
    logic [6:0]         x_cnt, y_cnt;

    interp_t pending_results [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      tx_gaps = 1'b1, rx_gaps = 1'b1;

    bilinear_grid_interpolator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_grid_col(s_grid_col), .s_grid_row(s_grid_row),
        .s_sample_0(s_sample_0), .s_sample_1(s_sample_1), .s_sample_2(s_sample_2),
        .s_sample_3(s_sample_3), .s_sample_4(s_sample_4),
        .s_point_x(s_point_x), .s_point_y(s_point_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value_0(m_value_0), .m_value_1(m_value_1), .m_value_2(m_value_2),
        .m_value_3(m_value_3), .m_value_4(m_value_4), .m_out_of_range(m_out_of_range),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Finds the cell and Q1.16 weight along one axis; returns 0 when outside.
    function automatic bit find_cell(input logic signed [31:0] p, input logic signed [31:0] org,
                                     input logic [31:0] inv, input logic [6:0] cnt,
                                     output int idx, output int w);
        longint n, d;
        logic [63:0] prod;
        idx = 0;
        w = 0;
        n = (cnt < 64) ? cnt : 64;
        d = longint'(p) - longint'(org);
        if (n < 2 || d < 0) return 1'b0;
        prod = 64'(d) * {32'd0, inv};
        if (prod[63:32] < n - 1) begin
            idx = int'(prod[63:32]);
            w = int'(prod[31:16]);
            return 1'b1;
        end
        if (prod[63:32] == n - 1 && prod[31:16] == 16'd0) begin
            idx = int'(n - 2);
            w = 65536;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic longint mix(input longint a, input longint b, input int w);
        longint s;
        s = a * (65536 - w) + b * w;
        return (s + 32768) >>> 16;
    endfunction

    function automatic interp_t interpolate(input logic signed [31:0] px,
                                            input logic signed [31:0] py);
        interp_t r;
        int cx, cy, wx, wy;
        longint lo, hi, v;
        r = '0;
        if (!find_cell(px, x_org, x_inv, x_cnt, cx, wx) ||
            !find_cell(py, y_org, y_inv, y_cnt, cy, wy)) begin
            r.oor = 1'b1;
            return r;
        end
        for (int k = 0; k < 5; k++) begin
            lo = mix(grid_store[k][cy][cx], grid_store[k][cy][cx+1], wx);
            hi = mix(grid_store[k][cy+1][cx], grid_store[k][cy+1][cx+1], wx);
            v = mix(lo, hi, wy);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.val[k] = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sample_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t load_word(input int col, input int row);
        word_t it;
        it = '0;
        it.col = col[5:0];
        it.row = row[5:0];
        for (int k = 0; k < 5; k++) it.smp[k] = sample_word();
        it.px = $urandom;
        it.py = $urandom;
        return it;
    endfunction

    function automatic word_t query_word(input logic [31:0] px, input logic [31:0] py);
        word_t it;
        it = '0;
        it.mode = 1'b1;
        it.col = 6'($urandom);
        it.row = 6'($urandom);
        for (int k = 0; k < 5; k++) it.smp[k] = $urandom;
        it.px = px;
        it.py = py;
        return it;
    endfunction

    // Coordinate mostly inside the used grid, sometimes just past it or anywhere.
    function automatic logic [31:0] pick_coord(input logic [31:0] org, input logic [31:0] inv,
                                               input logic [6:0] cnt);
        longint n, span, d;
        n = (cnt < 64) ? cnt : 64;
        if (n < 2 || $urandom_range(9) == 0) return sample_word();
        span = (inv == 0) ? 64'h7FFF_FFFF : ((n - 1) << 32) / inv;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        if ($urandom_range(4) == 0 && inv != 0)
            d = (longint'($urandom_range(n - 1)) << 32) / inv;
        else
            d = longint'($urandom) % (span + span / 16 + 2);
        return org + d[31:0];
    endfunction

    // Hands one word over and updates the model in order with the block.
    task automatic push_word(input word_t it);
        int gap;
        if (it.mode) begin
            if (it.typed) pending_results.push_back({it.val, it.oor});
            else pending_results.push_back(interpolate(it.px, it.py));
        end else begin
            for (int k = 0; k < 5; k++) grid_store[k][it.row][it.col] = it.smp[k];
            loaded[it.row][it.col] = 1'b1;
        end
        gap = tx_gaps ? $urandom_range(19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= it.mode;
        s_grid_col <= it.col;
        s_grid_row <= it.row;
        s_sample_0 <= it.smp[0];
        s_sample_1 <= it.smp[1];
        s_sample_2 <= it.smp[2];
        s_sample_3 <= it.smp[3];
        s_sample_4 <= it.smp[4];
        s_point_x <= it.px;
        s_point_y <= it.py;
        do @(posedge aclk); while (!s_ready);
    endtask

    // A query that lands in a cell first gets any corner that was never loaded.
    task automatic issue(input word_t it);
        int cx, cy, wx, wy;
        if (it.mode && find_cell(it.px, x_org, x_inv, x_cnt, cx, wx) &&
            find_cell(it.py, y_org, y_inv, y_cnt, cy, wy)) begin
            for (int dy = 0; dy < 2; dy++)
                for (int dx = 0; dx < 2; dx++)
                    if (!loaded[cy+dy][cx+dx]) push_word(load_word(cx + dx, cy + dy));
        end
        push_word(it);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({r, 2'b00});
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (r)
            REG_X_ORIGIN:   x_org = v;
            REG_Y_ORIGIN:   y_org = v;
            REG_X_INV_STEP: x_inv = v;
            REG_Y_INV_STEP: y_inv = v;
            REG_X_COUNT:    x_cnt = v[6:0];
            REG_Y_COUNT:    y_cnt = v[6:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_grid(input logic [31:0] xo, input logic [31:0] yo,
                            input logic [31:0] xi, input logic [31:0] yi,
                            input logic [31:0] xc, input logic [31:0] yc);
        drain();
        write_reg(REG_X_ORIGIN, xo);
        write_reg(REG_Y_ORIGIN, yo);
        write_reg(REG_X_INV_STEP, xi);
        write_reg(REG_Y_INV_STEP, yi);
        write_reg(REG_X_COUNT, xc);
        write_reg(REG_Y_COUNT, yc);
    endtask

    task automatic random_run();
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(9) < 3)
                issue(load_word($urandom_range(63), $urandom_range(63)));
            else
                issue(query_word(pick_coord(x_org, x_inv, x_cnt),
                                 pick_coord(y_org, y_inv, y_cnt)));
        end
    endtask

    // Result side: random back-pressure, one draw per word.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = rx_gaps ? $urandom_range(19) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        interp_t want, got;
        got = {m_value_4, m_value_3, m_value_2, m_value_1, m_value_0, m_out_of_range};
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = pending_results.pop_front();
                if (want != got) begin
                    mismatches++;
                    if (mismatches <= 10)
                        for (int k = 0; k < 5; k++)
                            $display("value_%0d: expected %h oor %b, got %h oor %b",
                                     k, want.val[k], want.oor, got.val[k], got.oor);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        word_t directed [$];
        word_t it;
        x_org = 0; y_org = 0; x_inv = ONE_Q16; y_inv = ONE_Q16; x_cnt = 64; y_cnt = 64;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_grid(0, 0, ONE_Q16, ONE_Q16, 64, 64);

        // Corners of cell zero at the sample extremes, then points around the edges.
        it = load_word(0, 0); it.smp = {5{32'h7FFF_FFFF}}; directed.push_back(it);
        it = load_word(1, 0); it.smp = {5{32'h8000_0000}}; directed.push_back(it);
        it = load_word(0, 1); it.smp = '0;                 directed.push_back(it);
        it = load_word(1, 1); it.smp = {5{32'hFFFF_FFFF}}; directed.push_back(it);
        it = query_word(0, 0); it.typed = 1; it.val = {5{32'h7FFF_FFFF}};
        directed.push_back(it);
        directed.push_back(query_word(32'h0000_8000, 32'h0000_8000));
        directed.push_back(query_word(32'h0001_0000, 0));
        it = query_word(32'hFFFF_FFFF, 0); it.typed = 1; it.oor = 1; directed.push_back(it);
        it = query_word(0, 32'h8000_0000); it.typed = 1; it.oor = 1; directed.push_back(it);
        it = query_word(32'h0040_0000, 0); it.typed = 1; it.oor = 1; directed.push_back(it);
        it = query_word(0, 32'h7FFF_FFFF); it.typed = 1; it.oor = 1; directed.push_back(it);
        it = query_word(32'h003F_0001, 0); it.typed = 1; it.oor = 1; directed.push_back(it);
        it = load_word(63, 63); it.smp = {32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0,
                                          32'hFFFF_FFFF}; directed.push_back(it);
        directed.push_back(query_word(32'h003F_0000, 32'h003F_0000));
        directed.push_back(query_word(32'h003E_FFFF, 32'h003E_FFFF));
        directed.push_back(query_word(32'h003E_8000, 32'h0000_0001));
        foreach (directed[i]) issue(directed[i]);

        random_run();
        tx_gaps = 1'b0;
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, ONE_Q16, ONE_Q16, 2, 2);
        random_run();
        rx_gaps = 1'b0;
        set_grid($urandom_range(255), -$urandom_range(255), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 127, 127);
        random_run();
        tx_gaps = 1'b1;
        set_grid(0, 0, 0, 0, 0, 1);
        random_run();
        rx_gaps = 1'b1;
        set_grid(32'hFFFA_8000, 32'h0003_0000, 32'h0002_0000, 32'h0000_C000, 37, 64);
        random_run();
        set_grid($urandom, $urandom, 12345, 32'h0001_8000, 64, 2);
        random_run();
        set_grid(-$urandom_range(32'h0040_0000), $urandom_range(32'h0040_0000), ONE_Q16,
                 ONE_Q16, $urandom_range(2, 64), $urandom_range(2, 64));
        random_run();
        drain();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
